### src/ghtq_pkg.sv
// Shared types and constants for the GPIO hold-time qualifier.
// Used by ghtq_regs, ghtq_lane and gpio_hold_time_qualifier; no dependencies.
`default_nettype none

package ghtq_pkg;

    localparam int PIN_SLOTS  = 8;   // width of every pin vector on the ports
    localparam int NUM_PINS   = 8;   // pins that are qualified, 1..PIN_SLOTS
    localparam int HOLD_WIDTH = 8;   // used bits of each threshold byte, 4..8
    localparam int STAMP_W    = 32;
    localparam int THR_W      = 64;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int IDX_LSB    = 3;   // registers sit at 8-byte steps

    localparam logic [PIN_SLOTS-1:0] ENABLE_RESET = 8'hFF;
    localparam logic [PIN_SLOTS-1:0] INVERT_RESET = 8'h00;
    localparam logic [THR_W-1:0]     THRESH_RESET = 64'h0F0F_0F0F_0F0F_0F0F;
    localparam logic [PIN_SLOTS-1:0] QUAL_RESET   = 8'hFF;

    typedef enum logic [ADDR_W-IDX_LSB-1:0] {
        REG_ENABLE   = 3'd0,
        REG_INVERT   = 3'd1,
        REG_THRESH   = 3'd2,
        REG_SIM_MODE = 3'd3,
        REG_SIM_PAT  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [PIN_SLOTS-1:0] enable_mask;
        logic [PIN_SLOTS-1:0] invert_mask;
        logic [THR_W-1:0]     thresholds;
        logic                 sim_mode;
        logic [PIN_SLOTS-1:0] sim_pattern;
    } cfg_t;

    typedef struct packed {
        logic                  enable;
        logic                  invert;
        logic [HOLD_WIDTH-1:0] threshold;
    } lane_cfg_t;

    typedef struct packed {
        logic qualified;
        logic pending;
    } lane_status_t;

    typedef struct packed {
        logic [PIN_SLOTS-1:0] pin_levels;
        logic [PIN_SLOTS-1:0] toggled_pins;
        logic [PIN_SLOTS-1:0] qualified_pins;
        logic [PIN_SLOTS-1:0] pending_pins;
    } result_t;

endpackage

`default_nettype wire

### src/ghtq_regs.sv
// Configuration register file with an APB-style access port.
// Depends on ghtq_pkg for the register map and the cfg_t bundle.
`default_nettype none

module ghtq_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ghtq_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ghtq_pkg::DATA_W-1:0] pwdata,
    output logic      [ghtq_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output ghtq_pkg::cfg_t                   cfg
);

    ghtq_pkg::cfg_t     cfg_reg;
    ghtq_pkg::cfg_t     cfg_next;
    ghtq_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = ghtq_pkg::reg_idx_t'(paddr[ghtq_pkg::ADDR_W-1:ghtq_pkg::IDX_LSB]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ghtq_pkg::REG_ENABLE:   cfg_next.enable_mask = pwdata[ghtq_pkg::PIN_SLOTS-1:0];
                ghtq_pkg::REG_INVERT:   cfg_next.invert_mask = pwdata[ghtq_pkg::PIN_SLOTS-1:0];
                ghtq_pkg::REG_THRESH:   cfg_next.thresholds  = pwdata[ghtq_pkg::THR_W-1:0];
                ghtq_pkg::REG_SIM_MODE: cfg_next.sim_mode    = pwdata[0];
                ghtq_pkg::REG_SIM_PAT:  cfg_next.sim_pattern = pwdata[ghtq_pkg::PIN_SLOTS-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_mask <= ghtq_pkg::ENABLE_RESET;
            cfg_reg.invert_mask <= ghtq_pkg::INVERT_RESET;
            cfg_reg.thresholds  <= ghtq_pkg::THRESH_RESET;
            cfg_reg.sim_mode    <= 1'b0;
            cfg_reg.sim_pattern <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            ghtq_pkg::REG_ENABLE:   prdata[ghtq_pkg::PIN_SLOTS-1:0] = cfg_reg.enable_mask;
            ghtq_pkg::REG_INVERT:   prdata[ghtq_pkg::PIN_SLOTS-1:0] = cfg_reg.invert_mask;
            ghtq_pkg::REG_THRESH:   prdata[ghtq_pkg::THR_W-1:0]     = cfg_reg.thresholds;
            ghtq_pkg::REG_SIM_MODE: prdata[0]                       = cfg_reg.sim_mode;
            ghtq_pkg::REG_SIM_PAT:  prdata[ghtq_pkg::PIN_SLOTS-1:0] = cfg_reg.sim_pattern;
            default:                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/ghtq_lane.sv
// One pin lane: pending/armed/qualified state and the hold-time timer stamp.
// Depends on ghtq_pkg for lane_cfg_t and lane_status_t.
`default_nettype none

module ghtq_lane (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  ghtq_pkg::lane_cfg_t               lcfg,
    input  wire logic                         sample,
    input  wire logic                         last,
    input  wire logic [ghtq_pkg::STAMP_W-1:0] now_ms,
    output ghtq_pkg::lane_status_t            status
);

    logic                         pending_reg, pending_next;
    logic                         armed_reg, armed_next;
    logic                         qual_reg, qual_next;
    logic [ghtq_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    logic [ghtq_pkg::STAMP_W-1:0] elapsed;
    logic [ghtq_pkg::STAMP_W-1:0] thr_ext;
    logic                         toggled;
    logic                         level;

    assign toggled = sample ^ last;
    assign level   = sample ^ lcfg.invert;
    assign thr_ext = {{(ghtq_pkg::STAMP_W-ghtq_pkg::HOLD_WIDTH){1'b0}}, lcfg.threshold};

    always_comb
    begin
        pending_next = pending_reg;
        armed_next   = armed_reg;
        qual_next    = qual_reg;
        stamp_next   = stamp_reg;
        if (toggled)
        begin
            if (!pending_reg && !level)
            begin
                pending_next = 1'b1;
                armed_next   = 1'b1;
                stamp_next   = now_ms;
            end
            else if (pending_reg && level)
            begin
                // drop the qualified value at once on release
                pending_next = 1'b0;
                armed_next   = 1'b0;
                qual_next    = 1'b0;
                stamp_next   = '0;
            end
        end
        elapsed = now_ms - stamp_next;
        if (pending_next && armed_next && (elapsed >= thr_ext))
        begin
            // qualify once per hold: disarm the timer
            armed_next = 1'b0;
            qual_next  = 1'b1;
            stamp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            armed_reg   <= 1'b0;
            qual_reg    <= 1'b1;
            stamp_reg   <= '0;
        end
        else if (step && lcfg.enable)
        begin
            pending_reg <= pending_next;
            armed_reg   <= armed_next;
            qual_reg    <= qual_next;
            stamp_reg   <= stamp_next;
        end
    end

    // disabled lanes read zero
    assign status.qualified = lcfg.enable & qual_next;
    assign status.pending   = lcfg.enable & pending_next;

endmodule

`default_nettype wire

### src/gpio_hold_time_qualifier.sv
// GPIO hold-time qualifier: eight pin lanes working side by side on each scan.
// Each accepted scan's result goes to the output register, or to the skid entry
// while the output is stalled. Throughput: one scan per cycle while the skid
// is empty; the output register plus skid form a two-entry decoupling buffer.
// Reset: rst_n clears all pin state, qualified values go to all ones, config
// registers take their documented defaults.
`default_nettype none

module gpio_hold_time_qualifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ghtq_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ghtq_pkg::DATA_W-1:0]   pwdata,
    output logic      [ghtq_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ghtq_pkg::PIN_SLOTS-1:0] raw_pins,
    input  wire logic [ghtq_pkg::STAMP_W-1:0]  now_ms,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [ghtq_pkg::PIN_SLOTS-1:0] pin_levels,
    output logic      [ghtq_pkg::PIN_SLOTS-1:0] toggled_pins,
    output logic      [ghtq_pkg::PIN_SLOTS-1:0] qualified_pins,
    output logic      [ghtq_pkg::PIN_SLOTS-1:0] pending_pins
);

    ghtq_pkg::cfg_t                 cfg;
    ghtq_pkg::lane_status_t         status [ghtq_pkg::PIN_SLOTS];
    ghtq_pkg::result_t              result;
    ghtq_pkg::result_t              out_data_reg, out_data_next;
    ghtq_pkg::result_t              skid_data_reg, skid_data_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           skid_valid_reg, skid_valid_next;
    logic [ghtq_pkg::PIN_SLOTS-1:0] last_sample_reg;
    logic [ghtq_pkg::PIN_SLOTS-1:0] sample;
    logic                           in_fire;
    logic                           out_fire;
    logic                           out_free;

    ghtq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || out_fire;

    assign sample = cfg.sim_mode ? cfg.sim_pattern : raw_pins;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
        end
        else if (in_fire)
        begin
            last_sample_reg <= sample;
        end
    end

    for (genvar p = 0; p < ghtq_pkg::PIN_SLOTS; p++)
    begin : g_lane
        if (p < ghtq_pkg::NUM_PINS)
        begin : g_used
            ghtq_pkg::lane_cfg_t lcfg;

            assign lcfg.enable    = cfg.enable_mask[p];
            assign lcfg.invert    = cfg.invert_mask[p];
            assign lcfg.threshold = cfg.thresholds[8*p +: ghtq_pkg::HOLD_WIDTH];

            ghtq_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .step   (in_fire),
                .lcfg   (lcfg),
                .sample (sample[p]),
                .last   (last_sample_reg[p]),
                .now_ms (now_ms),
                .status (status[p])
            );
        end
        else
        begin : g_unused
            assign status[p] = '0;
        end
    end

    // merge lane findings into one result
    always_comb
    begin
        result.pin_levels   = sample;
        result.toggled_pins = sample ^ last_sample_reg;
        for (int p = 0; p < ghtq_pkg::PIN_SLOTS; p++)
        begin
            result.qualified_pins[p] = status[p].qualified;
            result.pending_pins[p]   = status[p].pending;
        end
    end

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            // hold the new transaction while the output is stalled
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign pin_levels     = out_data_reg.pin_levels;
    assign toggled_pins   = out_data_reg.toggled_pins;
    assign qualified_pins = out_data_reg.qualified_pins;
    assign pending_pins   = out_data_reg.pending_pins;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted transaction did not reach the output");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("skid entry lost while output stalled");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !skid_valid_reg && !in_fire) |=> !out_valid_reg)
        else $error("output valid without a transaction behind it");

endmodule

`default_nettype wire

### bench/gpio_hold_time_qualifier_test.sv
`timescale 1ns / 100ps
// Self-checking bench for gpio_hold_time_qualifier: scans and register writes go in,
// results are checked against an in-bench qualifier model. Depends on ghtq_pkg.
module gpio_hold_time_qualifier_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam logic [ghtq_pkg::ADDR_W-ghtq_pkg::IDX_LSB-1:0] REG_SPARE = 3'd7;
    localparam logic [ghtq_pkg::PIN_SLOTS-1:0] PIN_FIELD =
        ghtq_pkg::PIN_SLOTS'((1 << ghtq_pkg::NUM_PINS) - 1);
    localparam logic [31:0] HOLD_MASK = (1 << ghtq_pkg::HOLD_WIDTH) - 1;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ghtq_pkg::ADDR_W-1:0]    paddr;
    logic [ghtq_pkg::DATA_W-1:0]    pwdata;
    logic [ghtq_pkg::DATA_W-1:0]    prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_stall;
    logic [ghtq_pkg::PIN_SLOTS-1:0] raw_pins;
    logic [ghtq_pkg::STAMP_W-1:0]   now_ms;
    logic                           out_valid;
    logic                           out_stall;
    logic [ghtq_pkg::PIN_SLOTS-1:0] pin_levels;
    logic [ghtq_pkg::PIN_SLOTS-1:0] toggled_pins;
    logic [ghtq_pkg::PIN_SLOTS-1:0] qualified_pins;
    logic [ghtq_pkg::PIN_SLOTS-1:0] pending_pins;

    gpio_hold_time_qualifier dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_pins       (raw_pins),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pin_levels     (pin_levels),
        .toggled_pins   (toggled_pins),
        .qualified_pins (qualified_pins),
        .pending_pins   (pending_pins)
    );

    // register shadows
    logic [ghtq_pkg::PIN_SLOTS-1:0] cfg_enable;
    logic [ghtq_pkg::PIN_SLOTS-1:0] cfg_invert;
    logic [ghtq_pkg::THR_W-1:0]     cfg_thresh;
    logic                           cfg_sim;
    logic [ghtq_pkg::PIN_SLOTS-1:0] cfg_sim_pat;

    // qualifier state
    logic [ghtq_pkg::PIN_SLOTS-1:0] prev_levels;
    logic [ghtq_pkg::PIN_SLOTS-1:0] pend_q;
    logic [ghtq_pkg::PIN_SLOTS-1:0] armed_q;
    logic [ghtq_pkg::PIN_SLOTS-1:0] qual_q;
    logic [ghtq_pkg::STAMP_W-1:0]   stamp_q [ghtq_pkg::PIN_SLOTS];

    ghtq_pkg::result_t scan_results_due [$];
    ghtq_pkg::result_t oldest_due;

    int  cycle_count;
    int  mismatches;
    int  scans_sent;
    int  results_checked;
    int  reg_writes;
    int  hold_offs;
    int  hold_off_seq;
    int  hold_off_seen;
    bit  tx_calm;
    bit  rx_calm;

    logic [ghtq_pkg::PIN_SLOTS-1:0] pin_drive;
    logic [ghtq_pkg::STAMP_W-1:0]   clock_ms;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, scan_results_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task report_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                     what, cycle_count, want, got);
    endtask

    task clear_qualifier_state;
        cfg_enable  = ghtq_pkg::ENABLE_RESET;
        cfg_invert  = ghtq_pkg::INVERT_RESET;
        cfg_thresh  = ghtq_pkg::THRESH_RESET;
        cfg_sim     = 1'b0;
        cfg_sim_pat = '0;
        prev_levels = '0;
        pend_q      = '0;
        armed_q     = '0;
        qual_q      = ghtq_pkg::QUAL_RESET;
        for (int p = 0; p < ghtq_pkg::PIN_SLOTS; p++)
            stamp_q[p] = '0;
    endtask

    // Advance the qualifier by one scan and queue the result it must produce.
    task qualify_scan(input logic [ghtq_pkg::PIN_SLOTS-1:0] raw,
                      input logic [ghtq_pkg::STAMP_W-1:0] now);
        ghtq_pkg::result_t              r;
        logic [ghtq_pkg::PIN_SLOTS-1:0] smp;
        logic [ghtq_pkg::PIN_SLOTS-1:0] tog;
        logic [ghtq_pkg::PIN_SLOTS-1:0] live;
        logic [31:0]                    thr;
        logic                           lvl;
        smp  = cfg_sim ? cfg_sim_pat : raw;
        tog  = smp ^ prev_levels;
        live = cfg_enable & PIN_FIELD;
        prev_levels = smp;
        for (int p = 0; p < ghtq_pkg::PIN_SLOTS; p++)
        begin
            if (live[p])
            begin
                if (tog[p])
                begin
                    lvl = smp[p] ^ cfg_invert[p];
                    if (!pend_q[p] && !lvl)
                    begin
                        pend_q[p]  = 1'b1;
                        armed_q[p] = 1'b1;
                        stamp_q[p] = now;
                    end
                    else if (pend_q[p] && lvl)
                    begin
                        pend_q[p]  = 1'b0;
                        armed_q[p] = 1'b0;
                        qual_q[p]  = 1'b0;
                        stamp_q[p] = '0;
                    end
                end
                if (pend_q[p] && armed_q[p])
                begin
                    thr = 32'(cfg_thresh[8*p +: 8]) & HOLD_MASK;
                    // elapsed time wraps with the stamp counter
                    if (ghtq_pkg::STAMP_W'(now - stamp_q[p]) >= thr)
                    begin
                        armed_q[p] = 1'b0;
                        qual_q[p]  = 1'b1;
                        stamp_q[p] = '0;
                    end
                end
            end
        end
        r.pin_levels     = smp;
        r.toggled_pins   = tog;
        r.qualified_pins = qual_q & live;
        r.pending_pins   = pend_q & live;
        scan_results_due.push_back(r);
    endtask

    function automatic logic [ghtq_pkg::DATA_W-1:0] shadow_of(
        input logic [ghtq_pkg::ADDR_W-ghtq_pkg::IDX_LSB-1:0] idx);
        case (idx)
            ghtq_pkg::REG_ENABLE:   return ghtq_pkg::DATA_W'(cfg_enable);
            ghtq_pkg::REG_INVERT:   return ghtq_pkg::DATA_W'(cfg_invert);
            ghtq_pkg::REG_THRESH:   return ghtq_pkg::DATA_W'(cfg_thresh);
            ghtq_pkg::REG_SIM_MODE: return ghtq_pkg::DATA_W'(cfg_sim);
            ghtq_pkg::REG_SIM_PAT:  return ghtq_pkg::DATA_W'(cfg_sim_pat);
            default:                return '0;
        endcase
    endfunction

    // Write one register, then read it back.
    task program_reg(input logic [ghtq_pkg::ADDR_W-ghtq_pkg::IDX_LSB-1:0] idx,
                     input logic [ghtq_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {ghtq_pkg::IDX_LSB{1'b0}}};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            ghtq_pkg::REG_ENABLE:   cfg_enable  = val[ghtq_pkg::PIN_SLOTS-1:0];
            ghtq_pkg::REG_INVERT:   cfg_invert  = val[ghtq_pkg::PIN_SLOTS-1:0];
            ghtq_pkg::REG_THRESH:   cfg_thresh  = val[ghtq_pkg::THR_W-1:0];
            ghtq_pkg::REG_SIM_MODE: cfg_sim     = val[0];
            ghtq_pkg::REG_SIM_PAT:  cfg_sim_pat = val[ghtq_pkg::PIN_SLOTS-1:0];
            default:                ;
        endcase
        reg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx <= ghtq_pkg::REG_SIM_PAT && prdata !== shadow_of(idx))
            report_mismatch("register readback", shadow_of(idx), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one scan and hold it until the transaction completes.
    task send_scan(input logic [ghtq_pkg::PIN_SLOTS-1:0] raw,
                   input logic [ghtq_pkg::STAMP_W-1:0] now);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_pins <= raw;
        now_ms   <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        qualify_scan(raw, now);
        scans_sent++;
    endtask

    // Drop valid and wait until every queued result has come back.
    task wait_for_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (scan_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [ghtq_pkg::THR_W-1:0] draw_thresholds(input int top);
        logic [ghtq_pkg::THR_W-1:0] t;
        for (int p = 0; p < ghtq_pkg::PIN_SLOTS; p++)
            t[8*p +: 8] = 8'($urandom_range(0, top));
        return t;
    endfunction

    // Pins flip a few bits per scan so holds build up; a few scans are pure noise.
    task run_scans(input int count, input int step_max, input bit sparse);
        logic [ghtq_pkg::PIN_SLOTS-1:0] flips;
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            flips = ghtq_pkg::PIN_SLOTS'($urandom & $urandom);
            if (sparse)
                flips &= ghtq_pkg::PIN_SLOTS'($urandom);
            pin_drive ^= flips;
            clock_ms += ghtq_pkg::STAMP_W'($urandom_range(0, step_max));
            if ($urandom_range(0, 9) == 0)
                pin_drive = ghtq_pkg::PIN_SLOTS'($urandom);
            if ($urandom_range(0, 39) == 0)
                clock_ms = $urandom;
            send_scan(pin_drive, clock_ms);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task restore_defaults;
        program_reg(ghtq_pkg::REG_ENABLE, ghtq_pkg::DATA_W'(ghtq_pkg::ENABLE_RESET));
        program_reg(ghtq_pkg::REG_INVERT, ghtq_pkg::DATA_W'(ghtq_pkg::INVERT_RESET));
        program_reg(ghtq_pkg::REG_THRESH, ghtq_pkg::DATA_W'(ghtq_pkg::THRESH_RESET));
        program_reg(ghtq_pkg::REG_SIM_MODE, '0);
        program_reg(ghtq_pkg::REG_SIM_PAT, '0);
    endtask

    task test_special_cases;
        send_scan(8'h00, 32'h0000_0000);
        send_scan(8'hFF, 32'h0000_0001);     // toggle to inactive while idle: no effect
        send_scan(8'h00, 32'hFFFF_FFF8);     // all pins go pending
        send_scan(8'h00, 32'hFFFF_FFFF);
        send_scan(8'h00, 32'h0000_0006);
        send_scan(8'h00, 32'h0000_0007);     // hold reached across the wrap
        send_scan(8'h00, 32'h0000_0008);     // qualifies once per hold
        send_scan(8'hFF, 32'h0000_0009);     // release drops qualified at once
        wait_for_results;
        program_reg(ghtq_pkg::REG_THRESH, 64'h0102_0408_1020_FF00);
        program_reg(ghtq_pkg::REG_ENABLE, 64'h7F);
        program_reg(ghtq_pkg::REG_INVERT, 64'h0F);
        send_scan(8'hFE, 32'd100);
        send_scan(8'hFF, 32'd101);           // zero threshold qualifies in the same scan
        send_scan(8'h7F, 32'd102);           // disabled pin toggles, state frozen
        send_scan(8'h0D, 32'd103);
        wait_for_results;
        program_reg(ghtq_pkg::REG_INVERT, 64'hFF);
        send_scan(8'h7D, 32'd110);           // toggle to active while already pending
        wait_for_results;
        program_reg(ghtq_pkg::REG_SIM_MODE, 64'h1);
        program_reg(ghtq_pkg::REG_SIM_PAT, 64'hA5);
        send_scan(8'h00, 32'd120);
        send_scan(8'hFF, 32'd121);
        wait_for_results;
        program_reg(ghtq_pkg::REG_SIM_PAT, 64'h5A);
        send_scan(8'h00, 32'd122);
        wait_for_results;
        program_reg(ghtq_pkg::REG_SIM_MODE, '0);
        program_reg(REG_SPARE, '1);          // unmapped index, must be ignored
        send_scan(8'hFF, 32'h8000_0000);
        wait_for_results;
        program_reg(ghtq_pkg::REG_ENABLE, '0);
        send_scan(8'h00, 32'h8000_0010);
        send_scan(8'hFF, 32'h8000_0020);
        wait_for_results;
        restore_defaults;
        pin_drive = 8'hFF;
        clock_ms  = 32'h8000_0100;
    endtask

    task test_random_configs;
        program_reg(ghtq_pkg::REG_THRESH, draw_thresholds(31));
        run_scans(150, 8, 1'b0);
        wait_for_results;
        program_reg(ghtq_pkg::REG_ENABLE, '0);
        run_scans(40, 8, 1'b0);
        wait_for_results;
        program_reg(ghtq_pkg::REG_ENABLE, ghtq_pkg::DATA_W'($urandom_range(0, 255)));
        program_reg(ghtq_pkg::REG_INVERT, 64'hFF);
        program_reg(ghtq_pkg::REG_THRESH, '0);
        run_scans(100, 4, 1'b0);
        wait_for_results;
        program_reg(ghtq_pkg::REG_ENABLE, 64'hFF);
        program_reg(ghtq_pkg::REG_INVERT, ghtq_pkg::DATA_W'($urandom_range(0, 255)));
        program_reg(ghtq_pkg::REG_THRESH, '1);
        run_scans(150, 96, 1'b1);
        wait_for_results;
        program_reg(ghtq_pkg::REG_SIM_MODE, 64'h1);
        program_reg(ghtq_pkg::REG_SIM_PAT, ghtq_pkg::DATA_W'($urandom_range(0, 255)));
        run_scans(30, 8, 1'b0);
        wait_for_results;
        program_reg(ghtq_pkg::REG_SIM_PAT, ghtq_pkg::DATA_W'($urandom_range(0, 255)));
        run_scans(30, 8, 1'b0);
        wait_for_results;
        program_reg(ghtq_pkg::REG_SIM_MODE, '0);
        program_reg(ghtq_pkg::REG_ENABLE, ghtq_pkg::DATA_W'($urandom_range(0, 255)));
        program_reg(ghtq_pkg::REG_INVERT, ghtq_pkg::DATA_W'($urandom_range(0, 255)));
        program_reg(ghtq_pkg::REG_THRESH, {$urandom, $urandom});
        run_scans(150, 64, 1'b1);
        wait_for_results;
    endtask

    task test_time_wrap;
        program_reg(ghtq_pkg::REG_ENABLE, 64'hFF);
        program_reg(ghtq_pkg::REG_THRESH, draw_thresholds(40));
        clock_ms = 32'hFFFF_FE00;
        run_scans(100, 12, 1'b0);
        wait_for_results;
    endtask

    task test_output_hold_off;
        tx_calm = 1'b1;
        hold_off_seq++;                      // receiver holds off in its own process
        run_scans(40, 6, 1'b0);
        wait_for_results;
    endtask

    task test_sender_pause;
        for (int b = 0; b < 3; b++)
        begin
            run_scans(20, 6, 1'b0);
            wait_for_results;
        end
    endtask

    // Output side: stall a drawn number of cycles before each transaction,
    // or hold off for a long stretch when asked.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_seq != hold_off_seen)
            begin
                hold_off_seen = hold_off_seq;
                hold_offs++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rst_n && out_valid && !out_stall)
            begin
                n = rx_calm ? 0 : $urandom_range(0, 4);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (scan_results_due.size() == 0)
                report_mismatch("unexpected result", '0,
                                64'({pin_levels, toggled_pins, qualified_pins, pending_pins}));
            else
            begin
                oldest_due = scan_results_due.pop_front();
                if (pin_levels !== oldest_due.pin_levels)
                    report_mismatch("pin_levels", 64'(oldest_due.pin_levels),
                                    64'(pin_levels));
                if (toggled_pins !== oldest_due.toggled_pins)
                    report_mismatch("toggled_pins", 64'(oldest_due.toggled_pins),
                                    64'(toggled_pins));
                if (qualified_pins !== oldest_due.qualified_pins)
                    report_mismatch("qualified_pins", 64'(oldest_due.qualified_pins),
                                    64'(qualified_pins));
                if (pending_pins !== oldest_due.pending_pins)
                    report_mismatch("pending_pins", 64'(oldest_due.pending_pins),
                                    64'(pending_pins));
                results_checked++;
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        raw_pins <= '0;
        now_ms   <= '0;
        cycle_count     = 0;
        mismatches      = 0;
        scans_sent      = 0;
        results_checked = 0;
        reg_writes      = 0;
        hold_offs       = 0;
        hold_off_seq    = 0;
        hold_off_seen   = 0;
        tx_calm         = 1'b0;
        rx_calm         = 1'b0;
        pin_drive       = '0;
        clock_ms        = '0;
        clear_qualifier_state;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases;
        test_random_configs;
        test_time_wrap;
        test_output_hold_off;
        test_sender_pause;

        wait_for_results;
        repeat (8) @(posedge clk);
        $display("ran %0d scans, checked %0d results, %0d register writes, %0d long hold-offs",
                 scans_sent, results_checked, reg_writes, hold_offs);
        $display("configs covered disabled and inverted pins, zero and full thresholds, sim mode");
        if (mismatches == 0 && scan_results_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
